// ===== sv/vsse_pkg.sv =====
// Shared types, constants and tables for the vehicle speed and steering estimator.
package vsse_pkg;

    // CORDIC iteration count default and table length
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_TAB_LEN   = 24;

    // Configuration port geometry
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [19:0] AXLE_RESET   = 20'd176947;
    localparam logic [25:0] GAP_RESET    = 26'd3000000;
    localparam logic [16:0] MINSPD_RESET = 17'd6554;

    // pi * 2e6 scaled for binary angle to radians, and microseconds per second
    localparam logic [22:0] PI_SCALE     = 23'd6283185;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    typedef enum logic [1:0] {
        CFG_AXLE_BASE = 2'd0,
        CFG_GAP_LIMIT = 2'd1,
        CFG_MIN_SPEED = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_GAP_LONG = 2'd1,
        ST_DT_BAD   = 2'd2,
        ST_FIRST    = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_SCALE,
        S_DIV,
        S_SPEED,
        S_DIR_INIT,
        S_DIR_ITER,
        S_SIGN,
        S_GATE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_NORM,
        S_STEER_ITER,
        S_STEER_OUT,
        S_DONE
    } state_t;

    // arctan(2^-i) as a 32-bit binary angle (2^31 is pi)
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] val;
        begin
            case (idx)
                5'd0:    val = 32'd536870912;
                5'd1:    val = 32'd316933406;
                5'd2:    val = 32'd167458907;
                5'd3:    val = 32'd85004756;
                5'd4:    val = 32'd42667331;
                5'd5:    val = 32'd21354465;
                5'd6:    val = 32'd10680862;
                5'd7:    val = 32'd5340245;
                5'd8:    val = 32'd2670163;
                5'd9:    val = 32'd1335087;
                5'd10:   val = 32'd667544;
                5'd11:   val = 32'd333772;
                5'd12:   val = 32'd166886;
                5'd13:   val = 32'd83443;
                5'd14:   val = 32'd41721;
                5'd15:   val = 32'd20860;
                5'd16:   val = 32'd10430;
                5'd17:   val = 32'd5215;
                5'd18:   val = 32'd2607;
                5'd19:   val = 32'd1303;
                5'd20:   val = 32'd651;
                5'd21:   val = 32'd325;
                5'd22:   val = 32'd162;
                5'd23:   val = 32'd81;
                default: val = 32'd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== sv/vsse_pose_if.sv =====
// Pose input channel: valid/ready handshake with the timestamped pose word.
interface vsse_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic        [47:0] time_us;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output time_us, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading,
                    input time_us, output ready);
endinterface

// ===== sv/vsse_result_if.sv =====
// Result output channel: valid/ready handshake with speed, steering and status.
interface vsse_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed;
    logic signed [15:0] steer_angle;
    logic        [1:0]  status;

    modport source (output valid, output speed, output steer_angle, output status,
                    input ready);
    modport sink   (input valid, input speed, input steer_angle, input status,
                     output ready);
endinterface

// ===== sv/vehicle_speed_steer_estimator_core.sv =====
// Speed and steering estimator: pose deltas through a sequenced sqrt/divide/CORDIC datapath.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+-------------------------------------------
//  pose     | in  | valid/ready    | pos_x, pos_y, heading, time_us
//  result   | out | valid/ready    | speed, steer_angle, status
//  cfg      | in  | cfg_we only    | cfg_index, cfg_data (axle, gap, min speed)
//
//  One word at a time. A zeroed case (first sample, long gap, bad dt) goes from the gap
//  check straight to output. A normal word runs 32 square-root steps, 53 divider steps,
//  up to 17 normalising shifts and two CORDIC runs on the shared rotator.
//  pose.ready is high only in idle; the finished word sits in the output register,
//  so a new pose is taken while the previous result still waits to be read.
//  Reset clears the stored pose, time, speed and config to their defaults.
module vehicle_speed_steer_estimator_core #(
    parameter int CORDIC_STEPS = vsse_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vsse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsse_pkg::CFG_W-1:0]       cfg_data,
    vsse_pose_if.sink                        pose,
    vsse_result_if.source                    result
);

    localparam int CordicIters = (CORDIC_STEPS < vsse_pkg::CORDIC_TAB_LEN) ?
                                 CORDIC_STEPS : vsse_pkg::CORDIC_TAB_LEN;
    localparam logic [5:0] CordicLast = 6'(CordicIters - 1);
    localparam logic [5:0] SqrtLast   = 6'd31;
    localparam logic [5:0] DivLast    = 6'd52;
    localparam logic signed [54:0] VMax = 55'sd2147483647;
    localparam logic signed [54:0] VMin = -55'sd2147483648;

    // control state
    vsse_pkg::state_t state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               have_prev_reg, have_prev_next;
    logic signed [31:0] last_x_reg, last_x_next;
    logic signed [31:0] last_y_reg, last_y_next;
    logic signed [15:0] last_hd_reg, last_hd_next;
    logic [47:0]        last_t_reg, last_t_next;
    logic signed [31:0] smooth_reg, smooth_next;
    logic [19:0]        axle_reg;
    logic [25:0]        gap_reg;
    logic [16:0]        minspd_reg;

    // datapath
    logic signed [31:0] cur_x_reg, cur_x_next;
    logic signed [31:0] cur_y_reg, cur_y_next;
    logic signed [15:0] cur_hd_reg, cur_hd_next;
    logic [47:0]        cur_t_reg, cur_t_next;
    logic [1:0]         status_reg, status_next;
    logic [25:0]        dt_reg, dt_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic               sh_reg, sh_next;
    logic [63:0]        n_reg, n_next;
    logic [63:0]        res_reg, res_next;
    logic [52:0]        num_reg, num_next;
    logic [25:0]        rem_reg, rem_next;
    logic signed [53:0] half_reg, half_next;
    logic signed [31:0] v_reg, v_next;
    logic [35:0]        p1_reg, p1_next;
    logic [58:0]        ym_reg, ym_next;
    logic [57:0]        xm_reg, xm_next;
    logic signed [43:0] cx_reg, cx_next;
    logic signed [43:0] cy_reg, cy_next;
    logic [31:0]        cz_reg, cz_next;
    logic signed [15:0] steer_reg, steer_next;
    logic signed [31:0] out_speed_reg, out_speed_next;
    logic signed [15:0] out_steer_reg, out_steer_next;
    logic [1:0]         out_status_reg, out_status_next;

    // combinational helpers
    logic [32:0]        ax_full, ay_full;
    logic               big;
    logic [31:0]        ax_h, ay_h;
    logic [63:0]        sq_bit, sq_trial;
    logic [32:0]        root_len;
    logic [26:0]        rem_sh;
    logic               rem_ge;
    logic signed [54:0] spd_sum;
    logic signed [43:0] xs, ys;
    logic               yneg;
    logic signed [43:0] cx_step, cy_step;
    logic [31:0]        cz_step, cz_round;
    logic signed [15:0] cordic_ang, hd_diff, dyaw;
    logic               flip;
    logic signed [54:0] vs;
    logic [31:0]        av;
    logic [15:0]        ady;
    logic [47:0]        t_fwd, t_back;
    logic [58:0]        ym_sum;

    assign pose.ready         = (state_reg == vsse_pkg::S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.speed       = out_speed_reg;
    assign result.steer_angle = out_steer_reg;
    assign result.status      = out_status_reg;

    // displacement magnitudes, halved together when either is huge
    always_comb
    begin
        ax_full = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay_full = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        big     = (|ax_full[32:31]) | (|ay_full[32:31]);
        ax_h    = big ? ax_full[32:1] : {1'b0, ax_full[30:0]};
        ay_h    = big ? ay_full[32:1] : {1'b0, ay_full[30:0]};
    end

    // square-root step, divider step, speed sum
    always_comb
    begin
        sq_bit   = 64'h4000_0000_0000_0000 >> {cnt_reg[4:0], 1'b0};
        sq_trial = res_reg + sq_bit;
        root_len = sh_reg ? {res_reg[31:0], 1'b0} : {1'b0, res_reg[31:0]};
        rem_sh   = {rem_reg, num_reg[52]};
        rem_ge   = (rem_sh >= {1'b0, dt_reg});
        spd_sum  = 55'(smooth_reg) + $signed({2'b00, num_reg});
    end

    // shared CORDIC rotator
    always_comb
    begin
        xs         = cx_reg >>> cnt_reg[4:0];
        ys         = cy_reg >>> cnt_reg[4:0];
        yneg       = cy_reg[43];
        cx_step    = yneg ? (cx_reg - ys) : (cx_reg + ys);
        cy_step    = yneg ? (cy_reg + xs) : (cy_reg - xs);
        cz_step    = yneg ? (cz_reg - vsse_pkg::atan_entry(cnt_reg[4:0]))
                          : (cz_reg + vsse_pkg::atan_entry(cnt_reg[4:0]));
        cz_round   = cz_reg + 32'd32768;
        cordic_ang = cz_round[31:16];
    end

    // direction sign, saturation, steering operands
    always_comb
    begin
        hd_diff = cur_hd_reg - cordic_ang;
        flip    = (hd_diff > 16'sd8192) || (hd_diff < -16'sd8192);
        vs      = flip ? -55'(half_reg) : 55'(half_reg);
        av      = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
        dyaw    = cur_hd_reg - last_hd_reg;
        ady     = dyaw[15] ? 16'(-dyaw) : 16'(dyaw);
        t_fwd   = cur_t_reg - last_t_reg;
        t_back  = last_t_reg - cur_t_reg;
        ym_sum  = ym_reg + (59'(p1_reg[35:18] * vsse_pkg::PI_SCALE) << 18);
    end

    // sequencer: next state and datapath loads
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        have_prev_next  = have_prev_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        last_hd_next    = last_hd_reg;
        last_t_next     = last_t_reg;
        smooth_next     = smooth_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        cur_hd_next     = cur_hd_reg;
        cur_t_next      = cur_t_reg;
        status_next     = status_reg;
        dt_next         = dt_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sh_next         = sh_reg;
        n_next          = n_reg;
        res_next        = res_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        half_next       = half_reg;
        v_next          = v_reg;
        p1_next         = p1_reg;
        ym_next         = ym_reg;
        xm_next         = xm_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        steer_next      = steer_reg;
        out_speed_next  = out_speed_reg;
        out_steer_next  = out_steer_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            vsse_pkg::S_IDLE:
            begin
                if (pose.valid)
                begin
                    cur_x_next  = pose.pos_x;
                    cur_y_next  = pose.pos_y;
                    cur_hd_next = pose.heading;
                    cur_t_next  = pose.time_us;
                    state_next  = vsse_pkg::S_CHECK;
                end
            end
            // classify the time gap
            vsse_pkg::S_CHECK:
            begin
                dt_next = t_fwd[25:0];
                dx_next = 33'(cur_x_reg) - 33'(last_x_reg);
                dy_next = 33'(cur_y_reg) - 33'(last_y_reg);
                if (!have_prev_reg)
                begin
                    status_next = vsse_pkg::ST_FIRST;
                end
                else if (cur_t_reg > last_t_reg)
                begin
                    status_next = (t_fwd > {22'd0, gap_reg}) ? vsse_pkg::ST_GAP_LONG
                                                             : vsse_pkg::ST_NORMAL;
                end
                else
                begin
                    status_next = (t_back > {22'd0, gap_reg}) ? vsse_pkg::ST_GAP_LONG
                                                              : vsse_pkg::ST_DT_BAD;
                end
                if (!have_prev_reg || (cur_t_reg <= last_t_reg) ||
                    (t_fwd > {22'd0, gap_reg}))
                begin
                    v_next     = '0;
                    steer_next = '0;
                    state_next = vsse_pkg::S_DONE;
                end
                else
                begin
                    state_next = vsse_pkg::S_SQX;
                end
            end
            vsse_pkg::S_SQX:
            begin
                n_next     = 64'(ax_h * ax_h);
                sh_next    = big;
                state_next = vsse_pkg::S_SQY;
            end
            vsse_pkg::S_SQY:
            begin
                n_next     = n_reg + 64'(ay_h * ay_h);
                res_next   = '0;
                cnt_next   = '0;
                state_next = vsse_pkg::S_SQRT;
            end
            // one root digit per cycle
            vsse_pkg::S_SQRT:
            begin
                if (n_reg >= sq_trial)
                begin
                    n_next   = n_reg - sq_trial;
                    res_next = (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SqrtLast)
                begin
                    state_next = vsse_pkg::S_SCALE;
                end
            end
            vsse_pkg::S_SCALE:
            begin
                num_next   = 53'(root_len * vsse_pkg::USEC_PER_SEC);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = vsse_pkg::S_DIV;
            end
            // restoring divide, one quotient bit per cycle
            vsse_pkg::S_DIV:
            begin
                rem_next = rem_ge ? 26'(rem_sh - {1'b0, dt_reg}) : rem_sh[25:0];
                num_next = {num_reg[51:0], rem_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DivLast)
                begin
                    state_next = vsse_pkg::S_SPEED;
                end
            end
            vsse_pkg::S_SPEED:
            begin
                half_next  = spd_sum[54:1];
                state_next = vsse_pkg::S_DIR_INIT;
            end
            vsse_pkg::S_DIR_INIT:
            begin
                cnt_next = '0;
                if ((dx_reg == 33'sd0) && (dy_reg == 33'sd0))
                begin
                    cz_next    = '0;
                    state_next = vsse_pkg::S_SIGN;
                end
                else
                begin
                    cx_next    = dx_reg[32] ? -44'(dx_reg) : 44'(dx_reg);
                    cy_next    = dx_reg[32] ? -44'(dy_reg) : 44'(dy_reg);
                    cz_next    = dx_reg[32] ? 32'h8000_0000 : 32'd0;
                    state_next = vsse_pkg::S_DIR_ITER;
                end
            end
            vsse_pkg::S_DIR_ITER:
            begin
                cx_next  = cx_step;
                cy_next  = cy_step;
                cz_next  = cz_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CordicLast)
                begin
                    state_next = vsse_pkg::S_SIGN;
                end
            end
            // reverse when heading opposes travel, then saturate
            vsse_pkg::S_SIGN:
            begin
                if (vs > VMax)
                begin
                    v_next = 32'sh7FFF_FFFF;
                end
                else if (vs < VMin)
                begin
                    v_next = 32'sh8000_0000;
                end
                else
                begin
                    v_next = vs[31:0];
                end
                state_next = vsse_pkg::S_GATE;
            end
            vsse_pkg::S_GATE:
            begin
                if (av > {15'd0, minspd_reg})
                begin
                    state_next = vsse_pkg::S_MUL1;
                end
                else
                begin
                    steer_next = '0;
                    state_next = vsse_pkg::S_DONE;
                end
            end
            vsse_pkg::S_MUL1:
            begin
                p1_next    = 36'(axle_reg * ady);
                state_next = vsse_pkg::S_MUL2;
            end
            vsse_pkg::S_MUL2:
            begin
                ym_next    = 59'(p1_reg[17:0] * vsse_pkg::PI_SCALE);
                xm_next    = 58'(av * dt_reg);
                state_next = vsse_pkg::S_MUL3;
            end
            vsse_pkg::S_MUL3:
            begin
                ym_next    = 59'(ym_sum[58:16]);
                state_next = vsse_pkg::S_NORM;
            end
            // bring both operands below 2^40
            vsse_pkg::S_NORM:
            begin
                cnt_next = '0;
                if ((|xm_reg[57:40]) || (|ym_reg[58:40]))
                begin
                    xm_next = xm_reg >> 1;
                    ym_next = ym_reg >> 1;
                end
                else if ((xm_reg == 58'd0) && (ym_reg == 59'd0))
                begin
                    steer_next = '0;
                    state_next = vsse_pkg::S_DONE;
                end
                else
                begin
                    cx_next    = $signed({4'd0, xm_reg[39:0]});
                    cy_next    = dyaw[15] ? -$signed({4'd0, ym_reg[39:0]})
                                          : $signed({4'd0, ym_reg[39:0]});
                    cz_next    = '0;
                    state_next = vsse_pkg::S_STEER_ITER;
                end
            end
            vsse_pkg::S_STEER_ITER:
            begin
                cx_next  = cx_step;
                cy_next  = cy_step;
                cz_next  = cz_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CordicLast)
                begin
                    state_next = vsse_pkg::S_STEER_OUT;
                end
            end
            vsse_pkg::S_STEER_OUT:
            begin
                steer_next = cordic_ang;
                state_next = vsse_pkg::S_DONE;
            end
            // hand over the word and commit the stored pose
            vsse_pkg::S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_speed_next  = v_reg;
                    out_steer_next  = steer_reg;
                    out_status_next = status_reg;
                    last_x_next     = cur_x_reg;
                    last_y_next     = cur_y_reg;
                    last_hd_next    = cur_hd_reg;
                    last_t_next     = cur_t_reg;
                    smooth_next     = v_reg;
                    have_prev_next  = 1'b1;
                    state_next      = vsse_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vsse_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vsse_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_hd_reg   <= '0;
            last_t_reg    <= '0;
            smooth_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            have_prev_reg <= have_prev_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            last_hd_reg   <= last_hd_next;
            last_t_reg    <= last_t_next;
            smooth_reg    <= smooth_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axle_reg   <= vsse_pkg::AXLE_RESET;
            gap_reg    <= vsse_pkg::GAP_RESET;
            minspd_reg <= vsse_pkg::MINSPD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (vsse_pkg::cfg_idx_t'(cfg_index))
                vsse_pkg::CFG_AXLE_BASE: axle_reg   <= cfg_data[19:0];
                vsse_pkg::CFG_GAP_LIMIT: gap_reg    <= cfg_data[25:0];
                vsse_pkg::CFG_MIN_SPEED: minspd_reg <= cfg_data[16:0];
                default:                 ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        cur_hd_reg     <= cur_hd_next;
        cur_t_reg      <= cur_t_next;
        status_reg     <= status_next;
        dt_reg         <= dt_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        sh_reg         <= sh_next;
        n_reg          <= n_next;
        res_reg        <= res_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        half_reg       <= half_next;
        v_reg          <= v_next;
        p1_reg         <= p1_next;
        ym_reg         <= ym_next;
        xm_reg         <= xm_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        steer_reg      <= steer_next;
        out_speed_reg  <= out_speed_next;
        out_steer_reg  <= out_steer_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    // an accepted pose always goes straight to gap classification
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (pose.valid && pose.ready) |=> (state_reg == vsse_pkg::S_CHECK))
        else $error("accepted pose did not enter gap check");

    // zeroed cases carry zero speed and steering
    a_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != vsse_pkg::ST_NORMAL)) |->
        ((result.speed == 32'sd0) && (result.steer_angle == 16'sd0)))
        else $error("non-normal status with non-zero output");

    // root loop never overruns its digit count
    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vsse_pkg::S_SQRT) |-> (cnt_reg <= SqrtLast))
        else $error("square-root counter overrun");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the vehicle speed and steering estimator core.
module testbench;

    localparam int  STEER_ITERS = 16;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  DRAIN_WAIT  = 250;
    localparam int  PHASES      = 5;
    localparam int  PHASE_WORDS = 168;

    // arctan(2^-i), 2^31 is pi
    localparam longint ATAN_LUT [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81
    };

    typedef struct {
        logic signed [31:0] speed;
        logic signed [15:0] steer;
        vsse_pkg::status_t  status;
    } motion_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] hd;
        logic        [47:0] t;
        bit                 typed;
        vsse_pkg::status_t  status;
    } pose_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [vsse_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vsse_pkg::CFG_W-1:0]     cfg_data;

    vsse_pose_if   pose_ch();
    vsse_result_if res_ch();

    vehicle_speed_steer_estimator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose_ch),
        .result    (res_ch)
    );

    // mirrored registers and estimator state
    longint   axle_q, gap_q, min_spd_q;
    longint   prev_x, prev_y, prev_t, avg_speed;
    logic signed [15:0] prev_hd;
    bit       seen_pose;

    motion_t  motion_q[$];
    bit       failed;
    bit       calm;
    int       cycles;

    // walking pose for random sequences
    logic signed [31:0] walk_x, walk_y;
    logic signed [15:0] walk_hd;
    logic        [47:0] walk_t;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog and quiet-stretch toggling
    initial
    begin
        cycles = 0;
        calm   = 1'b0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles % 700 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (cycles > CYCLE_LIMIT)
            begin
                $display("** vehicle_speed_steer_estimator_core: FAILED **");
                $finish;
            end
        end
    end

    function automatic longint root_floor(longint n);
        longint res, bit_v;
        res   = 0;
        bit_v = 64'sd1 <<< 62;
        while (bit_v > n) bit_v = bit_v >>> 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n   = n - (res + bit_v);
                res = (res >>> 1) + bit_v;
            end
            else
                res = res >>> 1;
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    // binary angle of vector (x, y) by vectoring rotations
    function automatic logic signed [15:0] bam_atan2(longint x, longint y);
        longint z, xs, ys, r;
        z = 0;
        if (x == 0 && y == 0) return 16'sd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 64'sd1 <<< 31;
        end
        for (int i = 0; i < STEER_ITERS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + ATAN_LUT[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - ATAN_LUT[i];
            end
        end
        r = (z + 32768) >>> 16;
        return r[15:0];
    endfunction

    // speed and steering for one pose; updates estimator state
    function automatic motion_t estimate_motion(logic signed [31:0] px, logic signed [31:0] py,
                                                logic signed [15:0] hd, logic [47:0] tw);
        motion_t m;
        longint  t, dt, dx, dy, ax, ay, dist_v, rate, v, av, ady, ym, xm;
        int      sh;
        logic signed [15:0] dyaw, dir, diff;
        t  = longint'(tw);
        dt = 0;
        v  = 0;
        m.steer = 16'sd0;
        if (!seen_pose)
            m.status = vsse_pkg::ST_FIRST;
        else if (t > prev_t)
        begin
            dt = t - prev_t;
            m.status = (dt > gap_q) ? vsse_pkg::ST_GAP_LONG : vsse_pkg::ST_NORMAL;
        end
        else
            m.status = (prev_t - t > gap_q) ? vsse_pkg::ST_GAP_LONG : vsse_pkg::ST_DT_BAD;

        if (m.status == vsse_pkg::ST_NORMAL)
        begin
            dx   = longint'(px) - prev_x;
            dy   = longint'(py) - prev_y;
            dyaw = hd - prev_hd;
            ax   = dx < 0 ? -dx : dx;
            ay   = dy < 0 ? -dy : dy;
            sh   = 0;
            // huge displacement: halve both before squaring
            if (ax >= (64'sd1 <<< 31) || ay >= (64'sd1 <<< 31))
            begin
                ax = ax >>> 1; ay = ay >>> 1; sh = 1;
            end
            dist_v = root_floor(ax * ax + ay * ay) <<< sh;
            rate = (dist_v * 1000000) / dt;
            v    = (avg_speed + rate) >>> 1;
            dir  = bam_atan2(dx, dy);
            diff = hd - dir;
            if (diff > 16'sd8192 || diff < -16'sd8192) v = -v;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            av = v < 0 ? -v : v;
            if (av > min_spd_q)
            begin
                ady = dyaw < 0 ? -longint'(dyaw) : longint'(dyaw);
                ym  = (axle_q * ady * 6283185) >>> 16;
                xm  = av * dt;
                while (xm >= (64'sd1 <<< 40) || ym >= (64'sd1 <<< 40))
                begin
                    xm = xm >>> 1; ym = ym >>> 1;
                end
                if (xm != 0 || ym != 0)
                    m.steer = bam_atan2(xm, dyaw < 0 ? -ym : ym);
            end
        end
        m.speed   = v[31:0];
        avg_speed = v;
        prev_x    = longint'(px);
        prev_y    = longint'(py);
        prev_hd   = hd;
        prev_t    = t;
        seen_pose = 1'b1;
        return m;
    endfunction

    // result side: random stalls and comparison against the oldest prediction
    initial
    begin
        int      stall;
        motion_t want;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                       : $urandom_range(20, 80);
            end
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (motion_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    want = motion_q.pop_front();
                    if (res_ch.speed !== want.speed)
                    begin
                        $error("speed: expected %0d actual %0d", want.speed, res_ch.speed);
                        failed = 1'b1;
                    end
                    if (res_ch.steer_angle !== want.steer)
                    begin
                        $error("steer_angle: expected %0d actual %0d",
                               want.steer, res_ch.steer_angle);
                        failed = 1'b1;
                    end
                    if (res_ch.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, res_ch.status);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // drive one pose word; called and returns at a falling edge
    task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [15:0] hd, logic [47:0] tw,
                             bit typed, vsse_pkg::status_t st);
        int      gap;
        motion_t m;
        gap = calm ? 0 : (($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                     : $urandom_range(15, 60));
        if (gap > 0)
        begin
            pose_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pose_ch.pos_x   = px;
        pose_ch.pos_y   = py;
        pose_ch.heading = hd;
        pose_ch.time_us = tw;
        pose_ch.valid   = 1'b1;
        do @(posedge clk); while (!pose_ch.ready);
        m = estimate_motion(px, py, hd, tw);
        // zeroed cases are known without the predictor
        if (typed)
        begin
            m.speed  = 32'sd0;
            m.steer  = 16'sd0;
            m.status = st;
        end
        motion_q.push_back(m);
        @(negedge clk);
    endtask

    // wait for every result, then let the core settle
    task automatic drain();
        pose_ch.valid = 1'b0;
        while (motion_q.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(vsse_pkg::cfg_idx_t idx, longint val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[vsse_pkg::CFG_W-1:0];
        case (idx)
            vsse_pkg::CFG_AXLE_BASE: axle_q    = val & 64'hFFFFF;
            vsse_pkg::CFG_GAP_LIMIT: gap_q     = val & 64'h3FFFFFF;
            vsse_pkg::CFG_MIN_SPEED: min_spd_q = val & 64'h1FFFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        pose_row_t rows[$];
        int        pick;
        longint    step;
        failed          = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pose_ch.valid   = 1'b0;
        pose_ch.pos_x   = '0;
        pose_ch.pos_y   = '0;
        pose_ch.heading = '0;
        pose_ch.time_us = '0;
        axle_q    = 176947;
        gap_q     = 3000000;
        min_spd_q = 6554;
        prev_x = 0; prev_y = 0; prev_t = 0; avg_speed = 0;
        prev_hd = '0; seen_pose = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows under reset values of the registers
        rows.push_back('{32'sd0, 32'sd0, 16'sd0, 48'd1000, 1, vsse_pkg::ST_FIRST});
        rows.push_back('{32'sd65536, 32'sd0, 16'sd0, 48'd101000, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd131072, 32'sd0, 16'sd0, 48'd201000, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd131072, 32'sd0, 16'sd0, 48'd201000, 1,
                         vsse_pkg::ST_DT_BAD});
        rows.push_back('{32'sd131072, 32'sd65536, 16'sd16384, 48'd301000, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd131072, 32'sd131072, 16'sd16384, 48'd3301001, 1,
                         vsse_pkg::ST_GAP_LONG});
        rows.push_back('{32'sd0, 32'sd0, 16'sd0, 48'd0, 1, vsse_pkg::ST_GAP_LONG});
        rows.push_back('{-32'sd2147483648, -32'sd2147483648, -16'sd32768, 48'd100, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd2147483647, 32'sd2147483647, 16'sd32767, 48'd200, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd2147483647, 32'sd2147483647, 16'sd8192, 48'd300, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd2147418111, 32'sd2147483647, 16'sd0, 48'd100300, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd2147352575, 32'sd2147483647, 16'sd0, 48'd200300, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd2147221503, 32'sd2147483647, 16'sd0, 48'd3200300, 0,
                         vsse_pkg::ST_NORMAL});
        rows.push_back('{32'sd2147221503, 32'sd2147483647, 16'sd0, 48'd3200295, 1,
                         vsse_pkg::ST_DT_BAD});
        rows.push_back('{32'sd2147221503, 32'sd2147483647, 16'sd0, 48'hFFFFFFFFFFFF, 1,
                         vsse_pkg::ST_GAP_LONG});
        rows.push_back('{32'sd0, 32'sd0, 16'sd0, 48'hFFFFFFFFFFFF, 1,
                         vsse_pkg::ST_DT_BAD});
        foreach (rows[i])
            send_pose(rows[i].x, rows[i].y, rows[i].hd, rows[i].t,
                      rows[i].typed, rows[i].status);

        walk_x = '0; walk_y = '0; walk_hd = '0; walk_t = 48'd1000;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_reg(vsse_pkg::CFG_AXLE_BASE, 0);
                    write_reg(vsse_pkg::CFG_GAP_LIMIT, 60000000);
                    write_reg(vsse_pkg::CFG_MIN_SPEED, 0);
                end
                1:
                begin
                    write_reg(vsse_pkg::CFG_AXLE_BASE, 655360);
                    write_reg(vsse_pkg::CFG_GAP_LIMIT, 0);
                    write_reg(vsse_pkg::CFG_MIN_SPEED, 65536);
                end
                2:
                begin
                    write_reg(vsse_pkg::CFG_AXLE_BASE, 655360);
                    write_reg(vsse_pkg::CFG_GAP_LIMIT, 60000000);
                    write_reg(vsse_pkg::CFG_MIN_SPEED, 0);
                end
                3:
                begin
                    write_reg(vsse_pkg::CFG_AXLE_BASE, $urandom_range(0, 655360));
                    write_reg(vsse_pkg::CFG_GAP_LIMIT, $urandom_range(100000, 60000000));
                    write_reg(vsse_pkg::CFG_MIN_SPEED, $urandom_range(0, 65536));
                end
                default:
                begin
                    write_reg(vsse_pkg::CFG_AXLE_BASE, 176947);
                    write_reg(vsse_pkg::CFG_GAP_LIMIT, 3000000);
                    write_reg(vsse_pkg::CFG_MIN_SPEED, 6554);
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    // plausible motion: small steps at frame-like intervals
                    step = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
                    walk_x = walk_x + step[31:0];
                    step = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
                    walk_y = walk_y + step[31:0];
                    if ($urandom_range(0, 9) == 0)
                        walk_hd = 16'($urandom());
                    else
                        walk_hd = walk_hd + 16'($urandom_range(0, 4000)) - 16'sd2000;
                    walk_t = walk_t + (($urandom_range(0, 9) == 0)
                                       ? 48'($urandom_range(1, 200))
                                       : 48'($urandom_range(5000, 150000)));
                end
                else if (pick < 90)
                begin
                    // broken timing: repeat, step back, or long jump
                    case ($urandom_range(0, 2))
                        0: ;
                        1: walk_t = walk_t - 48'($urandom_range(1, 50000));
                        default: walk_t = walk_t + 48'(gap_q) + 48'($urandom_range(1, 3));
                    endcase
                end
                else
                begin
                    walk_x  = $urandom();
                    walk_y  = $urandom();
                    walk_hd = 16'($urandom());
                    walk_t  = 48'({$urandom(), $urandom()});
                end
                send_pose(walk_x, walk_y, walk_hd, walk_t, 0, vsse_pkg::ST_NORMAL);
                // one mid-phase hold until the core has caught up
                if (ph == 2 && n == PHASE_WORDS / 2)
                    drain();
            end
        end

        pose_ch.valid = 1'b0;
        while (motion_q.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (motion_q.size() != 0)
        begin
            $error("results still expected at end of run: %0d", motion_q.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("** vehicle_speed_steer_estimator_core: PASSED **");
        else
            $display("** vehicle_speed_steer_estimator_core: FAILED **");
        $finish;
    end

endmodule
